// File: rtl/tle_pkg.sv
package tle_pkg;

	localparam int COUNT_W = 6;
	localparam int PEND_W  = 4;
	localparam logic [PEND_W-1:0] PEND_MAX = 4'd15;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_ETB   = 8'h17;
	localparam logic [7:0] CH_NAK   = 8'h15;

	localparam logic [2:0] KIND_ECHO      = 3'd0;
	localparam logic [2:0] KIND_NEWLINE   = 3'd1;
	localparam logic [2:0] KIND_ERASE     = 3'd2;
	localparam logic [2:0] KIND_LINE_BYTE = 3'd3;
	localparam logic [2:0] KIND_LINE_END  = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ECHO,
		S_NL,
		S_DELIV,
		S_LEND,
		S_ERASE,
		S_WORD
	} state_t;

endpackage

// File: rtl/tle_ram.sv
module tle_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 50,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/terminal_line_editor_echo_top.sv
// Line editor for a serial terminal, with echo.
// Input channel (in_valid/in_ready): one transfer is either a received byte
// (req_type 0, rx_byte, reader_open) or a line request from a reader (req_type 1).
// Output channel (out_valid/out_ready): one transfer per result, out_kind says
// echo, newline, erase one cell, line byte or line end; last marks the final
// result of the input item.
// An input transfer is taken only while the editor is idle. An item is
// decoded when it is taken, which starts the walk; its results then follow
// one per cycle while the output register can accept them, since the line
// buffer RAM returns one stored character per cycle. A line request or a
// dropped byte leaves the editor idle. At most 51 results follow from one item.
// The output register accepts a new result whenever it is empty or being
// taken, so a stalled receiver simply freezes the walk; nothing is lost.
// Reset clears the character count and the pending request count; the buffer
// contents are not cleared, as only characters below the count are ever read.
module terminal_line_editor_echo_top #(
	parameter int LINE_LEN = 50
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	input  logic       reader_open,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] out_kind,
	output logic [7:0] out_byte,
	output logic       last
);

	localparam int AW = $clog2(LINE_LEN);
	localparam logic [tle_pkg::COUNT_W-1:0] LEN_C = tle_pkg::COUNT_W'(LINE_LEN);

	tle_pkg::state_t state_q, state_d;
	logic [tle_pkg::COUNT_W-1:0] count_q, count_d;
	logic [tle_pkg::COUNT_W-1:0] idx_q, idx_d;
	logic [tle_pkg::COUNT_W-1:0] count_m1, count_m2, idx_p1;
	logic [tle_pkg::PEND_W-1:0]  pend_q, pend_d;
	logic [7:0] byte_q, byte_d;
	logic enter_q, enter_d;
	logic single_q, single_d;

	logic out_valid_q;
	logic [2:0] out_kind_q;
	logic [7:0] out_byte_q;
	logic last_q;

	logic can_put, put, put_last;
	logic [2:0] put_kind;
	logic [7:0] put_byte;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [7:0] ram_wd, ram_rd;

	// Writes happen only when an item is taken and reads only while one is
	// being walked, so a read never meets a write to the same entry.
	tle_ram #(
		.WIDTH (8),
		.DEPTH (LINE_LEN),
		.ADDR_W(AW)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wa),
		.wr_data(ram_wd),
		.rd_en  (ram_re),
		.rd_addr(ram_ra),
		.rd_data(ram_rd)
	);

	assign can_put  = !out_valid_q || out_ready;
	assign in_ready = (state_q == tle_pkg::S_IDLE);
	assign count_m1 = count_q - 1'b1;
	assign count_m2 = count_q - 2'd2;
	assign idx_p1   = idx_q + 1'b1;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		pend_d   = pend_q;
		byte_d   = byte_q;
		enter_d  = enter_q;
		single_d = single_q;
		ram_we   = 1'b0;
		ram_wa   = count_q[AW-1:0];
		ram_wd   = rx_byte;
		ram_re   = 1'b0;
		ram_ra   = count_m1[AW-1:0];
		put      = 1'b0;
		put_kind = tle_pkg::KIND_ECHO;
		put_byte = 8'h00;
		put_last = 1'b0;

		case (state_q)
			tle_pkg::S_IDLE: begin
				if (in_valid) begin
					if (req_type) begin
						if (pend_q != tle_pkg::PEND_MAX) begin
							pend_d = pend_q + 1'b1;
						end
					end else if (reader_open) begin
						if (rx_byte inside {[tle_pkg::CH_SPACE:tle_pkg::CH_DEL]}) begin
							ram_we  = 1'b1;
							byte_d  = rx_byte;
							count_d = count_q + 1'b1;
							state_d = tle_pkg::S_ECHO;
						end else begin
							case (rx_byte)
								tle_pkg::CH_CR: begin
									enter_d = 1'b1;
									state_d = tle_pkg::S_NL;
								end
								tle_pkg::CH_BS: begin
									if (count_q != '0) begin
										single_d = 1'b1;
										state_d  = tle_pkg::S_ERASE;
									end
								end
								tle_pkg::CH_ETB: begin
									if (count_q != '0) begin
										ram_re  = 1'b1;
										state_d = tle_pkg::S_WORD;
									end
								end
								tle_pkg::CH_NAK: begin
									if (count_q != '0) begin
										single_d = 1'b0;
										state_d  = tle_pkg::S_ERASE;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
			end
			tle_pkg::S_ECHO: begin
				if (can_put) begin
					put      = 1'b1;
					put_kind = tle_pkg::KIND_ECHO;
					put_byte = byte_q;
					if (count_q == LEN_C) begin
						enter_d = 1'b0;
						state_d = tle_pkg::S_NL;
					end else begin
						put_last = 1'b1;
						state_d  = tle_pkg::S_IDLE;
					end
				end
			end
			tle_pkg::S_NL: begin
				if (can_put) begin
					put      = 1'b1;
					put_kind = tle_pkg::KIND_NEWLINE;
					if (enter_q && pend_q != '0) begin
						pend_d = pend_q - 1'b1;
						idx_d  = '0;
						if (count_q != '0) begin
							ram_re  = 1'b1;
							ram_ra  = '0;
							state_d = tle_pkg::S_DELIV;
						end else begin
							state_d = tle_pkg::S_LEND;
						end
					end else begin
						put_last = 1'b1;
						count_d  = '0;
						state_d  = tle_pkg::S_IDLE;
					end
				end
			end
			tle_pkg::S_DELIV: begin
				if (can_put) begin
					put      = 1'b1;
					put_kind = tle_pkg::KIND_LINE_BYTE;
					put_byte = ram_rd;
					idx_d    = idx_p1;
					if (idx_p1 == count_q) begin
						state_d = tle_pkg::S_LEND;
					end else begin
						ram_re = 1'b1;
						ram_ra = idx_p1[AW-1:0];
					end
				end
			end
			tle_pkg::S_LEND: begin
				if (can_put) begin
					put      = 1'b1;
					put_kind = tle_pkg::KIND_LINE_END;
					put_last = 1'b1;
					count_d  = '0;
					state_d  = tle_pkg::S_IDLE;
				end
			end
			tle_pkg::S_ERASE: begin
				if (can_put) begin
					put      = 1'b1;
					put_kind = tle_pkg::KIND_ERASE;
					count_d  = count_m1;
					put_last = single_q || (count_m1 == '0);
					if (put_last) begin
						state_d = tle_pkg::S_IDLE;
					end
				end
			end
			tle_pkg::S_WORD: begin
				// The cell just read is erased; a space ends the word and is erased too.
				if (can_put) begin
					put      = 1'b1;
					put_kind = tle_pkg::KIND_ERASE;
					count_d  = count_m1;
					put_last = (ram_rd == tle_pkg::CH_SPACE) || (count_m1 == '0);
					if (put_last) begin
						state_d = tle_pkg::S_IDLE;
					end else begin
						ram_re = 1'b1;
						ram_ra = count_m2[AW-1:0];
					end
				end
			end
			default: begin
				state_d = tle_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tle_pkg::S_IDLE;
			count_q     <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			if (put) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		byte_q   <= byte_d;
		enter_q  <= enter_d;
		single_q <= single_d;
		if (put) begin
			out_kind_q <= put_kind;
			out_byte_q <= put_byte;
			last_q     <= put_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tle_pkg::S_IDLE) |-> (count_q < LEN_C))
		else $error("line count reached the line length while idle");

	a_store_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !req_type && reader_open &&
		 rx_byte >= tle_pkg::CH_SPACE && rx_byte <= tle_pkg::CH_DEL)
		|=> (state_q == tle_pkg::S_ECHO) && (count_q == $past(count_q) + 1'b1))
		else $error("printable byte not stored and echoed");

	a_pend_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tle_pkg::S_NL) |=> (pend_q >= $past(pend_q)))
		else $error("pending request count fell outside a newline");

	a_deliv_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tle_pkg::S_DELIV) |-> (idx_q < count_q))
		else $error("delivery index beyond stored characters");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		(put && put_last) |=> (state_q == tle_pkg::S_IDLE))
		else $error("final result given but editor not idle");
`endif

endmodule

// File: tb/terminal_line_editor_echo_top_test.sv
module terminal_line_editor_echo_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN = 50;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 64;

	localparam logic REQ_CHAR = 1'b0;
	localparam logic REQ_LINE = 1'b1;

	typedef struct {
		logic [2:0] kind;
		logic [7:0] data;
		logic       last;
	} term_out_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       req_type = REQ_CHAR;
	logic [7:0] rx_byte = 8'h00;
	logic       reader_open = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] out_kind;
	logic [7:0] out_byte;
	logic       last;

	// Own copy of the editor state, advanced on every accepted input transfer.
	logic [7:0]  line_chars [LINE_LEN];
	int          char_count = 0;
	logic [3:0]  line_reqs = '0;
	term_out_t   expected_out[$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit          quiet = 1'b0;
	int          stall_left = 0;

	terminal_line_editor_echo_top #(
		.LINE_LEN(LINE_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.rx_byte(rx_byte),
		.reader_open(reader_open),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void emit(logic [2:0] kind, logic [7:0] data);
		term_out_t r;
		r.kind = kind;
		r.data = data;
		r.last = 1'b0;
		expected_out.push_back(r);
	endfunction

	function automatic void edit_line(logic req, logic [7:0] ch, logic open);
		int start_n;
		int mark;
		int i;
		start_n = expected_out.size();
		if (char_count >= LINE_LEN)
			char_count = 0;
		if (req == REQ_LINE) begin
			if (line_reqs != tle_pkg::PEND_MAX)
				line_reqs++;
			return;
		end
		if (!open)
			return;
		if (ch >= tle_pkg::CH_SPACE && ch <= tle_pkg::CH_DEL) begin
			line_chars[char_count] = ch;
			char_count++;
			emit(tle_pkg::KIND_ECHO, ch);
			if (char_count >= LINE_LEN) begin
				emit(tle_pkg::KIND_NEWLINE, 8'h00);
				char_count = 0;
			end
		end else if (ch == tle_pkg::CH_CR) begin
			emit(tle_pkg::KIND_NEWLINE, 8'h00);
			if (line_reqs != 0) begin
				for (i = 0; i < char_count; i++)
					emit(tle_pkg::KIND_LINE_BYTE, line_chars[i]);
				emit(tle_pkg::KIND_LINE_END, 8'h00);
				line_reqs--;
			end
			char_count = 0;
		end else if (ch == tle_pkg::CH_BS) begin
			if (char_count > 0) begin
				emit(tle_pkg::KIND_ERASE, 8'h00);
				char_count--;
			end
		end else if (ch == tle_pkg::CH_ETB) begin
			// The erase runs back to the last space and takes the space with it.
			mark = 0;
			for (i = char_count - 1; i >= 0; i--) begin
				if (line_chars[i] == tle_pkg::CH_SPACE) begin
					mark = i;
					break;
				end
			end
			while (char_count > mark) begin
				emit(tle_pkg::KIND_ERASE, 8'h00);
				char_count--;
			end
		end else if (ch == tle_pkg::CH_NAK) begin
			while (char_count > 0) begin
				emit(tle_pkg::KIND_ERASE, 8'h00);
				char_count--;
			end
		end
		if (expected_out.size() > start_n)
			expected_out[$].last = 1'b1;
	endfunction

	// Leaves valid high after the transfer so that the next item may follow at once.
	task automatic send_item(logic req, logic [7:0] ch, logic open);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		rx_byte <= ch;
		reader_open <= open;
		do @(posedge clk); while (!in_ready);
		edit_line(req, ch, open);
	endtask

	task automatic send_char(logic [7:0] ch);
		send_item(REQ_CHAR, ch, 1'b1);
	endtask

	function automatic logic [7:0] random_printable();
		if ($urandom_range(0, 5) == 0)
			return tle_pkg::CH_SPACE;
		return 8'($urandom_range(8'h21, 8'h7F));
	endfunction

	task automatic send_random_chars(int len);
		repeat (len) send_char(random_printable());
	endtask

	task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
				act_val);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		term_out_t r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected result, kind %0d byte %0h last %0b", $time,
					out_kind, out_byte, last);
				error_count++;
			end else begin
				r = expected_out.pop_front();
				compare_field("out_kind", r.kind, out_kind);
				compare_field("out_byte", r.data, out_byte);
				compare_field("last", r.last, last);
			end
		end
	end

	// Receiver back-pressure: occasional bursts of stalled cycles.
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic test_closed_reader();
		send_item(REQ_CHAR, 8'h41, 1'b0);
		send_item(REQ_CHAR, tle_pkg::CH_CR, 1'b0);
	endtask

	task automatic test_printable_and_erase();
		send_char(tle_pkg::CH_SPACE);
		send_char(tle_pkg::CH_DEL);
		send_char(8'h41);
		send_char(tle_pkg::CH_BS);
		send_char(tle_pkg::CH_ETB);
		send_char(tle_pkg::CH_BS);
		send_char(tle_pkg::CH_ETB);
		send_char(8'h61);
		send_char(8'h62);
		send_char(tle_pkg::CH_SPACE);
		send_char(8'h63);
		send_char(tle_pkg::CH_ETB);
		send_char(tle_pkg::CH_ETB);
		send_char(8'h78);
		send_char(8'h79);
		send_char(tle_pkg::CH_NAK);
		send_char(tle_pkg::CH_NAK);
	endtask

	task automatic test_ignored_bytes();
		send_char(8'h00);
		send_char(8'h1F);
		send_char(8'h80);
		send_char(8'hFF);
	endtask

	task automatic test_enter();
		send_char(tle_pkg::CH_CR);
		// A request is counted even with no reader open.
		send_item(REQ_LINE, 8'h00, 1'b0);
		send_char(8'h68);
		send_char(8'h69);
		send_char(tle_pkg::CH_CR);
		send_char(tle_pkg::CH_CR);
		send_item(REQ_LINE, 8'hFF, 1'b1);
		send_char(tle_pkg::CH_CR);
	endtask

	task automatic test_long_lines();
		// A full line of 49 characters delivered gives the longest walk.
		send_item(REQ_LINE, 8'h00, 1'b1);
		send_random_chars(LINE_LEN - 1);
		send_char(tle_pkg::CH_CR);
		send_random_chars(LINE_LEN);
		send_random_chars(LINE_LEN + 2);
		send_char(tle_pkg::CH_CR);
	endtask

	task automatic test_request_saturation();
		repeat (18) send_item(REQ_LINE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		repeat (16) begin
			send_random_chars($urandom_range(0, 3));
			send_char(tle_pkg::CH_CR);
		end
	endtask

	task automatic test_random_editing(int items);
		int pick;
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_char(random_printable());
			else if (pick < 63)
				send_char(tle_pkg::CH_BS);
			else if (pick < 69)
				send_char(tle_pkg::CH_ETB);
			else if (pick < 72)
				send_char(tle_pkg::CH_NAK);
			else if (pick < 82)
				send_char(tle_pkg::CH_CR);
			else if (pick < 90)
				send_item(REQ_LINE, 8'($urandom_range(0, 255)), 1'b1);
			else
				send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_closed_reader();
		test_printable_and_erase();
		test_ignored_bytes();
		test_enter();
		test_long_lines();
		test_request_saturation();
		test_random_editing(200);
		quiet = 1'b1;
		test_random_editing(60);
		in_valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_out.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: terminal_line_editor_echo_top.f
rtl/tle_pkg.sv
rtl/tle_ram.sv
rtl/terminal_line_editor_echo_top.sv
tb/terminal_line_editor_echo_top_test.sv
